[rtl/gra_pkg.sv]
package gra_pkg;

    localparam int CMD_BITS = 3;
    localparam int CFG_BITS = 5;
    localparam int SIZE_BITS = 5;
    localparam int POS_BITS = 4;
    localparam int CNT_BITS = 9;
    localparam logic [CNT_BITS-1:0] COUNT_MAX = 9'd511;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PLACE  = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_CHECK  = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_COUNT  = 3'd4,
        CMD_PROBE  = 3'd5,
        CMD_CLEAR  = 3'd6,
        CMD_BAD    = 3'd7
    } cmd_t;

    typedef enum logic {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } reg_idx_t;

endpackage

[rtl/grid_rectangle_allocator.sv]
// Rectangle allocator over a grid of owner ids held in one synchronous RAM (one
// write or one read a cycle, read data registered and valid in the cycle after
// the read). Place and remove write the rectangle one cell a cycle; check reads
// each cell through the S_RECT and S_WAIT states and stops at the first occupied
// cell. Find walks the candidate positions up to the first free one and count
// walks every candidate position; inside each, they read every cell up to the
// first occupied one. Reset and CMD_CLEAR sweep the RAM one cell a cycle (one
// pass over the RAM); no beat is taken during that sweep. Config writes do not
// touch the cells.
module grid_rectangle_allocator #(
    parameter int MAX_COLS = 16,
    parameter int MAX_ROWS = 16,
    parameter int ID_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[2:0], pos_x[6:3], pos_y[10:7], rect_w[15:11], rect_h[20:16], owner_id[36:21]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], found_x[4:1], found_y[8:5], fit_count[17:9], cell_owner[33:18]
    output logic [39:0] m_tdata
);
    localparam int CX = $clog2(MAX_COLS) > 0 ? $clog2(MAX_COLS) : 1;
    localparam int CY = $clog2(MAX_ROWS) > 0 ? $clog2(MAX_ROWS) : 1;
    localparam int AW = CX + CY;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_RECT, S_WAIT, S_OUT} state_t;

    logic [ID_BITS-1:0] mem [DEPTH];
    logic [ID_BITS-1:0] rd_data;
    logic [AW-1:0] raddr;
    logic          rd_en, wr_en;
    logic [AW-1:0] waddr;
    logic [ID_BITS-1:0] wdata;

    state_t state_reg;
    logic [4:0] cols_reg, rows_reg;
    gra_pkg::cmd_t cmd_reg;
    logic [5:0] w_reg, h_reg;
    logic [5:0] bx_reg, by_reg;   // rectangle origin
    logic [5:0] cx_reg, cy_reg;   // offset inside rectangle
    logic [ID_BITS-1:0] id_reg;
    logic [AW:0] clr_reg;
    logic ok_reg;
    logic [3:0] fx_reg, fy_reg;
    logic [gra_pkg::CNT_BITS-1:0] cnt_reg;
    logic [ID_BITS-1:0] own_reg;
    logic out_valid_reg;

    logic [5:0] ecols, erows;
    assign ecols = (int'(cols_reg) > MAX_COLS) ? 6'(MAX_COLS) : 6'(cols_reg);
    assign erows = (int'(rows_reg) > MAX_ROWS) ? 6'(MAX_ROWS) : 6'(rows_reg);

    gra_pkg::cmd_t in_cmd;
    logic [3:0] in_x, in_y;
    logic [4:0] in_w, in_h;
    logic [15:0] in_id;
    logic [ID_BITS-1:0] in_idm;
    assign in_cmd = gra_pkg::cmd_t'(s_tdata[2:0]);
    assign in_x   = s_tdata[6:3];
    assign in_y   = s_tdata[10:7];
    assign in_w   = s_tdata[15:11];
    assign in_h   = s_tdata[20:16];
    assign in_id  = s_tdata[36:21];
    always_comb
    begin
        in_idm = '0;
        for (int i = 0; i < ID_BITS && i < 16; i++)
            in_idm[i] = in_id[i];
    end

    logic in_rect_ok, in_size_ok;
    assign in_rect_ok = in_w != 0 && in_h != 0
        && (6'(in_x) + 6'(in_w) <= ecols) && (6'(in_y) + 6'(in_h) <= erows);
    assign in_size_ok = in_w != 0 && in_h != 0
        && 6'(in_w) <= ecols && 6'(in_h) <= erows;

    logic [5:0] cc, cr;
    assign cc = bx_reg + cx_reg;
    assign cr = by_reg + cy_reg;
    logic [AW-1:0] cur_addr;
    assign cur_addr = {cr[CY-1:0], cc[CX-1:0]};

    logic last_cell;
    assign last_cell = (cy_reg + 6'd1 == h_reg) && (cx_reg + 6'd1 == w_reg);
    logic scan_cmd;
    assign scan_cmd = cmd_reg == gra_pkg::CMD_FIND || cmd_reg == gra_pkg::CMD_COUNT;
    logic last_pos_row, last_pos;
    assign last_pos_row = by_reg + h_reg >= erows;
    assign last_pos = last_pos_row && (bx_reg + w_reg >= ecols);

    assign s_tready = state_reg == S_IDLE && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, 16'(own_reg), cnt_reg, fy_reg, fx_reg, ok_reg};

    always_comb
    begin
        rd_en = 1'b0;
        wr_en = 1'b0;
        waddr = cur_addr;
        wdata = id_reg;
        raddr = cur_addr;
        unique case (state_reg)
            S_CLR:
            begin
                wr_en = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = '0;
            end
            S_RECT:
            begin
                if (cmd_reg == gra_pkg::CMD_PLACE || cmd_reg == gra_pkg::CMD_REMOVE)
                    wr_en = 1'b1;
                else
                    rd_en = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr] <= wdata;
        if (rd_en)
            rd_data <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            cols_reg <= 5'd16;
            rows_reg <= 5'd16;
            out_valid_reg <= 1'b0;
            cmd_reg <= gra_pkg::CMD_BAD;
            w_reg <= '0;
            h_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
            id_reg <= '0;
            ok_reg <= 1'b0;
            fx_reg <= '0;
            fy_reg <= '0;
            cnt_reg <= '0;
            own_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (gra_pkg::reg_idx_t'(cfg_index) == gra_pkg::REG_COLS)
                    cols_reg <= cfg_data;
                else
                    rows_reg <= cfg_data;
            end
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(DEPTH - 1))
                    begin
                        clr_reg <= '0;
                        state_reg <= (cmd_reg == gra_pkg::CMD_CLEAR) ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        cmd_reg <= in_cmd;
                        id_reg <= (in_cmd == gra_pkg::CMD_REMOVE) ? '0 : in_idm;
                        w_reg <= 6'(in_w);
                        h_reg <= 6'(in_h);
                        cx_reg <= '0;
                        cy_reg <= '0;
                        ok_reg <= 1'b0;
                        fx_reg <= '0;
                        fy_reg <= '0;
                        cnt_reg <= '0;
                        own_reg <= '0;
                        bx_reg <= 6'(in_x);
                        by_reg <= 6'(in_y);
                        state_reg <= S_OUT;
                        priority case (in_cmd)
                            gra_pkg::CMD_PLACE:
                                if (in_rect_ok && in_idm != 0) state_reg <= S_RECT;
                            gra_pkg::CMD_REMOVE, gra_pkg::CMD_CHECK:
                                if (in_rect_ok) state_reg <= S_RECT;
                            gra_pkg::CMD_FIND, gra_pkg::CMD_COUNT:
                                if (in_size_ok)
                                begin
                                    bx_reg <= '0;
                                    by_reg <= '0;
                                    state_reg <= S_RECT;
                                end
                            gra_pkg::CMD_PROBE:
                                if (6'(in_x) < ecols && 6'(in_y) < erows)
                                begin
                                    w_reg <= 6'd1;
                                    h_reg <= 6'd1;
                                    state_reg <= S_RECT;
                                end
                            gra_pkg::CMD_CLEAR:
                            begin
                                ok_reg <= 1'b1;
                                state_reg <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RECT:
                begin
                    if (wr_en)
                    begin
                        if (cy_reg + 6'd1 == h_reg)
                        begin
                            cy_reg <= '0;
                            cx_reg <= cx_reg + 6'd1;
                        end
                        else
                            cy_reg <= cy_reg + 6'd1;
                        if (last_cell)
                        begin
                            ok_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    // evaluate the cell read last cycle
                    state_reg <= S_RECT;
                    if (cmd_reg == gra_pkg::CMD_PROBE)
                    begin
                        ok_reg <= 1'b1;
                        own_reg <= rd_data;
                        state_reg <= S_OUT;
                    end
                    else if (rd_data != 0 || last_cell)
                    begin
                        // rectangle done: empty if this cell empty and all before
                        cx_reg <= '0;
                        cy_reg <= '0;
                        if (!scan_cmd)
                        begin
                            ok_reg <= rd_data == 0;
                            state_reg <= S_OUT;
                        end
                        else if (rd_data == 0 && cmd_reg == gra_pkg::CMD_FIND)
                        begin
                            ok_reg <= 1'b1;
                            fx_reg <= bx_reg[3:0];
                            fy_reg <= by_reg[3:0];
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            if (rd_data == 0 && cnt_reg != gra_pkg::COUNT_MAX)
                                cnt_reg <= cnt_reg + 1'b1;
                            if (cmd_reg == gra_pkg::CMD_COUNT)
                                ok_reg <= 1'b1;
                            if (last_pos)
                                state_reg <= S_OUT;
                            else if (last_pos_row)
                            begin
                                by_reg <= '0;
                                bx_reg <= bx_reg + 6'd1;
                            end
                            else
                                by_reg <= by_reg + 6'd1;
                        end
                    end
                    else if (cy_reg + 6'd1 == h_reg)
                    begin
                        cy_reg <= '0;
                        cx_reg <= cx_reg + 6'd1;
                    end
                    else
                        cy_reg <= cy_reg + 6'd1;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !rd_en)
        else $error("read and write in one cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid || $past(m_tvalid))
        else $error("result before work");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !s_tready)
        else $error("beat taken during clear");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

endmodule
